>>> sv/polyphonic_linear_envelope_vca_defines.svh
// Assertion macros shared by the envelope amplifier RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef POLYPHONIC_LINEAR_ENVELOPE_VCA_DEFINES_SVH
`define POLYPHONIC_LINEAR_ENVELOPE_VCA_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLEVCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLEVCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/plevca_pkg.sv
// Package for the polyphonic envelope amplifier: item types, voice state, constants.
// Depends on nothing; used by the top level.
`default_nettype none

package plevca_pkg;

   localparam int VOICES   = 8;
   localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Item kinds.
   localparam logic KIND_NOTE   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_AMP_MAX      = 2'd0;
   localparam logic [1:0] CSR_ATTACK_STEP  = 2'd1;
   localparam logic [1:0] CSR_RELEASE_STEP = 2'd2;

   localparam logic [15:0] FULL_SCALE         = 16'd32768;
   localparam logic [15:0] AMP_MAX_RESET      = 16'd32768;
   localparam logic [15:0] ATTACK_STEP_RESET  = 16'd137;
   localparam logic [15:0] RELEASE_STEP_RESET = 16'd137;

   // Division by 127 of a value below 2**22 as a multiply by ceil(2**29 / 127).
   localparam int          PROD_W      = 22;
   localparam int          RECIP_SHIFT = 29;
   localparam logic [22:0] RECIP_K     = 23'd4227331;

   // Rounding offset for the Q1.15 product.
   localparam logic signed [33:0] ROUND_HALF = 34'sd16384;

   // Result queue.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic              kind;
      logic [2:0]        voice;
      logic [6:0]        velocity;
      logic signed [15:0] sample_in;
   } req_type;

   typedef struct packed {
      logic [2:0]        voice_out;
      logic signed [15:0] sample_out;
      logic              still_active;
   } rsp_type;

   typedef struct packed {
      logic        gate_open;
      logic [15:0] amplitude;
      logic [15:0] target_level;
      logic        voice_on;
   } voice_state_type;

   localparam int STATE_W = $bits(voice_state_type);

endpackage

`default_nettype wire

>>> sv/polyphonic_linear_envelope_vca.sv
// Polyphonic linear attack/release envelope amplifier, top level.
// Depends on plevca_pkg, plevca_ram and polyphonic_linear_envelope_vca_defines.svh.
//
// The req channel carries items of two kinds. A note item opens a voice's gate
// (nonzero velocity) or closes it (zero velocity) and yields no result. A sample
// item moves that voice's amplitude one step and yields one rsp item holding the
// scaled sample and whether the voice is still active afterwards.
// The csr port writes amp_max, attack_step and release_step; it is to be used
// only while the block is idle, which the block itself does not enforce.
// Throughput is one item per cycle while req_ready stays high. Every item passes
// through a five-stage pipeline built around a voice state RAM: the read of the
// voice state is issued in stage 2, and the state is updated and written back in
// stage 3, with the previous write forwarded when the same voice follows directly.
// A sample item's result is written from stage 5 into an eight-entry result queue
// and offered on rsp_valid from there. When the receiver stalls, the queue absorbs
// results; req_ready drops only once the items in flight plus the queued results
// reach the queue depth, so no result is ever lost. Reset is synchronous: the
// registers return to their defaults and every voice reads as silent and inactive.

`default_nettype none

`include "polyphonic_linear_envelope_vca_defines.svh"

module polyphonic_linear_envelope_vca
   import plevca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [15:0] amp_max_ff;
   logic [15:0] attack_step_ff;
   logic [15:0] release_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_max_ff      <= AMP_MAX_RESET;
         attack_step_ff  <= ATTACK_STEP_RESET;
         release_step_ff <= RELEASE_STEP_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_AMP_MAX:      amp_max_ff      <= csr_wdata;
            CSR_ATTACK_STEP:  attack_step_ff  <= csr_wdata;
            CSR_RELEASE_STEP: release_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flow control: pending counts accepted items not yet dropped or delivered.
   logic              req_accept;
   logic              rsp_pop;
   logic              note_drop;
   logic [PEND_W-1:0] pending_ff;
   logic [PEND_W-1:0] pending_in;

   assign req_ready  = (pending_ff < PEND_W'(FIFO_DEPTH));
   assign req_accept = req_valid & req_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_accept) begin
         pending_in = pending_in + PEND_W'(1);
      end
      if (rsp_pop) begin
         pending_in = pending_in - PEND_W'(1);
      end
      if (note_drop) begin
         pending_in = pending_in - PEND_W'(1);
      end
   end

   // Stage 1: accepted item; the clipped amp_max is multiplied by the velocity.
   logic          s1_valid_ff;
   req_type       s1_item_ff;
   logic [15:0]   amp_lim;
   logic [22:0]   s2_prod_full;

   assign amp_lim      = (amp_max_ff > FULL_SCALE) ? FULL_SCALE : amp_max_ff;
   assign s2_prod_full = {7'd0, amp_lim} * {16'd0, s1_item_ff.velocity};

   // Stage 2: divide the product by 127 and issue the state RAM read.
   logic              s2_valid_ff;
   req_type           s2_item_ff;
   logic [PROD_W-1:0] s2_prod_ff;
   logic [44:0]       s3_recip_full;
   logic [15:0]       s3_target_in;
   logic              s2_in_range;
   logic [VOICE_AW-1:0] s2_addr;

   assign s3_recip_full = {23'd0, s2_prod_ff} * {22'd0, RECIP_K};
   assign s3_target_in  = s3_recip_full[RECIP_SHIFT+15:RECIP_SHIFT];
   assign s2_in_range   = (int'(s2_item_ff.voice) < VOICES);
   assign s2_addr       = s2_item_ff.voice[VOICE_AW-1:0];

   // Stage 3: read-modify-write of the voice state.
   logic                s3_valid_ff;
   req_type             s3_item_ff;
   logic [15:0]         s3_target_ff;
   logic                s3_mem_valid_ff;
   logic                s3_in_range;
   logic [VOICE_AW-1:0] s3_addr;
   logic [STATE_W-1:0]  ram_rdata;
   voice_state_type     cur_state;
   voice_state_type     nxt_state;
   logic [15:0]         s4_amp_in;
   logic                s4_still_in;
   logic [16:0]         rise_sum;
   logic                state_wr;

   // Entries never written since reset read as zero through these bits.
   logic [VOICES-1:0]   entry_valid_ff;

   // Write of the previous cycle, forwarded when the same voice follows.
   logic                fwd_valid_ff;
   logic [VOICE_AW-1:0] fwd_addr_ff;
   voice_state_type     fwd_state_ff;

   assign s3_in_range = (int'(s3_item_ff.voice) < VOICES);
   assign s3_addr     = s3_item_ff.voice[VOICE_AW-1:0];
   assign state_wr    = s3_valid_ff & s3_in_range;
   assign note_drop   = s3_valid_ff & (s3_item_ff.kind == KIND_NOTE);

   plevca_ram #(
      .WIDTH (STATE_W),
      .DEPTH (VOICES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (state_wr),
      .wr_addr (s3_addr),
      .wr_data (nxt_state),
      .rd_addr (s2_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s3_addr)) begin
         cur_state = fwd_state_ff;
      end else if (s3_mem_valid_ff) begin
         cur_state = voice_state_type'(ram_rdata);
      end else begin
         cur_state = '0;
      end

      nxt_state   = cur_state;
      rise_sum    = {1'b0, cur_state.amplitude} + {1'b0, attack_step_ff};
      s4_amp_in   = FULL_SCALE;
      s4_still_in = 1'b0;

      if (s3_item_ff.kind == KIND_NOTE) begin
         if (s3_item_ff.velocity != 7'd0) begin
            nxt_state.gate_open    = 1'b1;
            nxt_state.target_level = s3_target_ff;
            nxt_state.amplitude    = 16'd0;
            nxt_state.voice_on     = 1'b1;
         end else if (cur_state.voice_on) begin
            nxt_state.gate_open = 1'b0;
         end
      end else if (s3_in_range && cur_state.voice_on) begin
         if (cur_state.gate_open) begin
            if (rise_sum > {1'b0, cur_state.target_level}) begin
               nxt_state.amplitude = cur_state.target_level;
            end else begin
               nxt_state.amplitude = rise_sum[15:0];
            end
         end else if (cur_state.amplitude < release_step_ff) begin
            nxt_state.amplitude = 16'd0;
         end else begin
            nxt_state.amplitude = cur_state.amplitude - release_step_ff;
         end
         // A closed gate at zero amplitude ends the voice after this sample.
         nxt_state.voice_on = cur_state.gate_open | (nxt_state.amplitude != 16'd0);
         s4_amp_in          = nxt_state.amplitude;
         s4_still_in        = nxt_state.voice_on;
      end
   end

   // Stage 4: sample times amplitude. A sample of an inactive voice uses full
   // scale, which passes it through unchanged.
   logic                s4_valid_ff;
   logic [2:0]          s4_voice_ff;
   logic signed [15:0]  s4_sample_ff;
   logic [15:0]         s4_amp_ff;
   logic                s4_still_ff;
   logic signed [32:0]  s5_prod_in;

   assign s5_prod_in = s4_sample_ff * $signed({1'b0, s4_amp_ff});

   // Stage 5: round half up, shift back to Q1.15 and saturate.
   logic                s5_valid_ff;
   logic [2:0]          s5_voice_ff;
   logic                s5_still_ff;
   logic signed [32:0]  s5_prod_ff;
   logic signed [33:0]  rounded;
   logic signed [18:0]  scaled;
   rsp_type             push_item;

   assign rounded = $signed({s5_prod_ff[32], s5_prod_ff}) + ROUND_HALF;
   assign scaled  = rounded[33:15];

   always_comb begin
      push_item.voice_out    = s5_voice_ff;
      push_item.still_active = s5_still_ff;
      if (scaled > 19'sd32767) begin
         push_item.sample_out = 16'sh7fff;
      end else if (scaled < -19'sd32768) begin
         push_item.sample_out = 16'sh8000;
      end else begin
         push_item.sample_out = scaled[15:0];
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         pending_ff     <= '0;
      end else begin
         s1_valid_ff  <= req_accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff & (s3_item_ff.kind == KIND_SAMPLE);
         s5_valid_ff  <= s4_valid_ff;
         fwd_valid_ff <= state_wr;
         if (state_wr) begin
            entry_valid_ff[s3_addr] <= 1'b1;
         end
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff      <= req_data;
      s2_item_ff      <= s1_item_ff;
      s2_prod_ff      <= s2_prod_full[PROD_W-1:0];
      s3_item_ff      <= s2_item_ff;
      s3_target_ff    <= s3_target_in;
      s3_mem_valid_ff <= s2_in_range & entry_valid_ff[s2_addr];
      fwd_addr_ff     <= s3_addr;
      fwd_state_ff    <= nxt_state;
      s4_voice_ff     <= s3_item_ff.voice;
      s4_sample_ff    <= s3_item_ff.sample_in;
      s4_amp_ff       <= s4_amp_in;
      s4_still_ff     <= s4_still_in;
      s5_voice_ff     <= s4_voice_ff;
      s5_still_ff     <= s4_still_ff;
      s5_prod_ff      <= s5_prod_in;
   end

   // Result queue.
   rsp_type            fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] fifo_wr_ptr_ff;
   logic [FIFO_AW-1:0] fifo_rd_ptr_ff;
   logic [PEND_W-1:0]  fifo_count_ff;
   logic [PEND_W-1:0]  fifo_count_in;

   assign rsp_valid = (fifo_count_ff != '0);
   assign rsp_data  = fifo_mem_ff[fifo_rd_ptr_ff];
   assign rsp_pop   = rsp_valid & rsp_ready;

   always_comb begin
      fifo_count_in = fifo_count_ff;
      if (s5_valid_ff) begin
         fifo_count_in = fifo_count_in + PEND_W'(1);
      end
      if (rsp_pop) begin
         fifo_count_in = fifo_count_in - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ptr_ff <= '0;
         fifo_rd_ptr_ff <= '0;
         fifo_count_ff  <= '0;
      end else begin
         if (s5_valid_ff) begin
            fifo_wr_ptr_ff <= fifo_wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_pop) begin
            fifo_rd_ptr_ff <= fifo_rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff) begin
         fifo_mem_ff[fifo_wr_ptr_ff] <= push_item;
      end
   end

   // The credit count never exceeds the queue depth.
   `PLEVCA_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1,
      pending_ff <= PEND_W'(FIFO_DEPTH), "pending item count exceeds queue depth")

   // Queued results are always covered by the credit count.
   `PLEVCA_ASSERT_NOW(a_queue_in_credit, clock, reset, 1'b1,
      fifo_count_ff <= pending_ff, "result queue holds more than the pending items")

   // A result never arrives at a full queue.
   `PLEVCA_ASSERT_NOW(a_no_overflow, clock, reset, s5_valid_ff,
      (fifo_count_ff < PEND_W'(FIFO_DEPTH)) || rsp_pop, "result pushed into a full queue")

   // A note-on leaves its voice active with the gate open and zero amplitude.
   `PLEVCA_ASSERT_NEXT(a_note_on_state, clock, reset,
      state_wr && (s3_item_ff.kind == KIND_NOTE) && (s3_item_ff.velocity != 7'd0),
      fwd_valid_ff && fwd_state_ff.voice_on && fwd_state_ff.gate_open &&
      (fwd_state_ff.amplitude == 16'd0), "note-on did not restart the voice")

endmodule

`default_nettype wire

>>> sv/plevca_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; a read of the address written in the same cycle returns old data.
`default_nettype none

module plevca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> bench/polyphonic_linear_envelope_vca_tb.sv
// Self-checking testbench for the polyphonic linear envelope amplifier.
// Depends on plevca_pkg and the polyphonic_linear_envelope_vca RTL; reads no files.

module polyphonic_linear_envelope_vca_tb;
   import plevca_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // A run is stopped when this many cycles pass with no item accepted on
   // either channel. The longest correct pause is the deliberate receiver hold-off.
   localparam int STALL_LIMIT = 3000;

   // Every sample item ends in a result from the pipeline. Note items have
   // no result, so before a register write we let this many edges pass.
   localparam int SETTLE_CYCLES = 12;

   localparam int MAX_PRINTED = 40;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wen   = 1'b0;
   logic [1:0]  csr_index = CSR_AMP_MAX;
   logic [15:0] csr_wdata = '0;

   polyphonic_linear_envelope_vca dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Shadow copy of the block's registers and of the per-voice envelope state.
   logic [15:0] cfg_peak = AMP_MAX_RESET;
   logic [15:0] cfg_rise = ATTACK_STEP_RESET;
   logic [15:0] cfg_fall = RELEASE_STEP_RESET;

   logic        voice_gate     [VOICES] = '{default: 1'b0};
   logic [15:0] voice_level    [VOICES] = '{default: 16'd0};
   logic [15:0] voice_ceiling  [VOICES] = '{default: 16'd0};
   logic        voice_sounding [VOICES] = '{default: 1'b0};

   // Scaled samples that the block still owes us, oldest first.
   rsp_type scaled_due[$];

   int mismatches   = 0;
   int quiet_cycles = 0;

   // Traffic shaping. A calm side never idles; hold_off counts down the cycles
   // in which the receiver refuses results regardless of anything else.
   bit tx_calm  = 1'b0;
   bit rx_calm  = 1'b0;
   int hold_off = 0;

   // Applies one accepted item to the shadow state. Returns 1 when the item
   // produces a result, and fills that result in.
   function automatic bit apply_envelope(input req_type it, output rsp_type res);
      int unsigned v;
      int unsigned peak;
      int unsigned amp;
      longint      prod;
      v = it.voice;
      res.voice_out    = it.voice;
      res.sample_out   = it.sample_in;
      res.still_active = 1'b0;
      if (it.kind == KIND_NOTE) begin
         if (v < VOICES) begin
            if (it.velocity != 7'd0) begin
               // Anything above full scale behaves as full scale.
               peak = (cfg_peak > FULL_SCALE) ? FULL_SCALE : cfg_peak;
               voice_gate[v]     = 1'b1;
               voice_ceiling[v]  = 16'((peak * it.velocity) / 127);
               voice_level[v]    = 16'd0;
               voice_sounding[v] = 1'b1;
            end else if (voice_sounding[v]) begin
               voice_gate[v] = 1'b0;
            end
         end
         return 1'b0;
      end
      // A silent voice passes its sample through untouched.
      if (v >= VOICES || !voice_sounding[v])
         return 1'b1;
      amp = voice_level[v];
      if (voice_gate[v]) begin
         amp = amp + cfg_rise;
         if (amp > voice_ceiling[v])
            amp = voice_ceiling[v];
      end else begin
         amp = (amp < cfg_fall) ? 0 : amp - cfg_fall;
      end
      voice_level[v] = amp[15:0];
      // Q1.15 product, half added and floored, so ties go toward +infinity.
      prod = (longint'($signed(it.sample_in)) * longint'(voice_level[v]) + 64'sd16384) >>> 15;
      if (prod > 32767)
         prod = 32767;
      else if (prod < -32768)
         prod = -32768;
      res.sample_out = prod[15:0];
      if (!voice_gate[v] && voice_level[v] == 16'd0)
         voice_sounding[v] = 1'b0;
      res.still_active = voice_sounding[v];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Offers one item and holds it until accepted, then updates the shadow
   // state. Valid stays high when the next item follows without a gap, so the
   // caller must lower it with settle() once a burst is over.
   task automatic send_item(input req_type it);
      rsp_type res;
      req_valid <= 1'b1;
      req_data  <= it;
      do
         @(posedge clock);
      while (!req_ready);
      if (apply_envelope(it, res))
         scaled_due.push_back(res);
      if (!tx_calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < 28);
      end
   endtask

   // The unused field of each kind carries random bits, which the block must ignore.
   task automatic note(input int voice, input int velocity);
      req_type it;
      it.kind      = KIND_NOTE;
      it.voice     = voice[2:0];
      it.velocity  = velocity[6:0];
      it.sample_in = 16'($urandom);
      send_item(it);
   endtask

   task automatic sample(input int voice, input int value);
      req_type it;
      it.kind      = KIND_SAMPLE;
      it.voice     = voice[2:0];
      it.velocity  = 7'($urandom);
      it.sample_in = value[15:0];
      send_item(it);
   endtask

   // Lowers valid, waits for every owed result and then lets the pipeline run
   // dry, since trailing note items leave no result to wait on.
   task automatic settle();
      req_valid <= 1'b0;
      while (scaled_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; csr_wen is lowered again before the task returns, so writes never overlap.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_AMP_MAX:      cfg_peak = value;
         CSR_ATTACK_STEP:  cfg_rise = value;
         CSR_RELEASE_STEP: cfg_fall = value;
         default: ;
      endcase
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_envelope(input int peak, input int rise, input int fall);
      write_csr(CSR_AMP_MAX, peak[15:0]);
      write_csr(CSR_ATTACK_STEP, rise[15:0]);
      write_csr(CSR_RELEASE_STEP, fall[15:0]);
   endtask

   // Default registers: pass-through on silent voices, attack clipping at a
   // small target, release down to deactivation and a retrigger.
   task automatic test_pass_through_and_attack();
      sample(0, -32768);
      note(1, 0);            // note off on a silent voice changes nothing
      sample(1, 32767);
      note(2, 127);
      sample(2, -32768);
      sample(2, 32767);
      note(3, 1);            // target 258, so the second step clips
      sample(3, 100);
      sample(3, -100);
      note(3, 0);
      sample(3, 20000);
      sample(3, 20000);      // reaches zero and goes silent
      note(2, 64);           // retrigger restarts from zero
      sample(2, 12345);
      sample(7, 32767);
      settle();
   endtask

   // An out-of-range peak acts as full scale; half amplitude checks rounding ties.
   task automatic test_full_scale_and_rounding();
      program_envelope(65535, 16384, 32768);
      note(0, 127);
      sample(0, 1);          // amplitude one half: 0.5 rounds up to 1
      note(1, 127);
      sample(1, -1);         // -0.5 rounds up to 0
      sample(0, 32767);
      sample(0, -32768);
      note(0, 0);
      sample(0, 5);
      sample(0, 7);
      settle();
   endtask

   // Zero steps hold the amplitude; a zero peak gives a zero target.
   task automatic test_zero_steps();
      program_envelope(32768, 0, 0);
      note(4, 100);
      sample(4, 1000);       // held at zero while the gate is open
      note(4, 0);
      sample(4, 1000);       // closed at zero amplitude, so it goes silent
      settle();
      program_envelope(32768, 5000, 0);
      note(5, 127);
      sample(5, -30000);
      sample(5, 30000);
      note(5, 0);
      sample(5, 30000);      // no release step, so the voice keeps sounding
      settle();
      program_envelope(0, 300, 32768);
      sample(5, -2222);
      note(6, 127);
      sample(6, 32767);
      settle();
   endtask

   function automatic req_type random_item();
      req_type it;
      it.voice     = 3'($urandom_range(VOICES - 1));
      it.velocity  = 7'($urandom);
      it.sample_in = 16'($urandom);
      case ($urandom_range(9))
         0: it.sample_in = 16'sh8000;
         1: it.sample_in = 16'sh7FFF;
         default: ;
      endcase
      if ($urandom_range(99) < 15) begin
         it.kind = KIND_NOTE;
         if ($urandom_range(3) == 0)
            it.velocity = 7'd0;
      end else begin
         it.kind = KIND_SAMPLE;
      end
      return it;
   endfunction

   // Random notes and samples over several register settings, including the
   // extremes. One setting runs with both sides never idling.
   task automatic test_random_envelopes();
      int peak;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_envelope(AMP_MAX_RESET, ATTACK_STEP_RESET, RELEASE_STEP_RESET);
            1: program_envelope(1, 1, 1);
            2: program_envelope(32768, 32768, 32768);
            default: begin
               peak = ($urandom_range(3) == 0) ? $urandom_range(32769, 65535)
                                               : $urandom_range(32768);
               program_envelope(peak, $urandom_range(1, 3000), $urandom_range(1, 3000));
            end
         endcase
         tx_calm = (phase == 3);
         rx_calm = (phase == 3);
         repeat (90) send_item(random_item());
         settle();
      end
      tx_calm = 1'b0;
      rx_calm = 1'b0;
   endtask

   // The receiver refuses results for a long stretch while items keep coming,
   // so the result queue fills and the block must stall its input.
   task automatic test_backpressure();
      program_envelope(32768, 700, 400);
      tx_calm  = 1'b1;
      hold_off = 300;
      for (int v = 0; v < VOICES; v++)
         note(v, $urandom_range(1, 127));
      for (int k = 0; k < 60; k++)
         sample($urandom_range(VOICES - 1), $urandom);
      tx_calm = 1'b0;
      settle();
   endtask

   // The receiver process alone drives rsp_ready.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ready <= rx_calm || ($urandom_range(99) >= 28);
         end
      end
   end

   // Every accepted result is matched against the oldest owed one.
   always @(posedge clock) begin : check_scaled
      rsp_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scaled_due.size() == 0) begin
            report_mismatch($sformatf("result for voice %0d with nothing owed",
                                      rsp_data.voice_out));
         end else begin
            owed = scaled_due.pop_front();
            if (rsp_data.voice_out !== owed.voice_out)
               report_mismatch($sformatf("voice_out %0d, expected %0d",
                                         rsp_data.voice_out, owed.voice_out));
            if (rsp_data.sample_out !== owed.sample_out)
               report_mismatch($sformatf("voice %0d sample_out %0d, expected %0d",
                                         owed.voice_out, $signed(rsp_data.sample_out),
                                         $signed(owed.sample_out)));
            if (rsp_data.still_active !== owed.still_active)
               report_mismatch($sformatf("voice %0d still_active %0b, expected %0b",
                                         owed.voice_out, rsp_data.still_active,
                                         owed.still_active));
         end
      end
   end

   // Ends a hung run: too long with nothing accepted on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : run
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_pass_through_and_attack();
      test_full_scale_and_rounding();
      test_zero_steps();
      test_random_envelopes();
      test_backpressure();
      if (scaled_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", scaled_due.size()));
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
